/* rtl/core/largest_remainder_file_apportion_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the file apportionment block
// Same-cycle and next-cycle implication checks on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LARGEST_REMAINDER_FILE_APPORTION_TOP_ASSERT_SVH
`define LARGEST_REMAINDER_FILE_APPORTION_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LRFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrfa same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LRFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrfa next-cycle check failed");

`endif

/* rtl/core/lrfa_pkg.sv */
// ----------------------------------------------------------------------------
// lrfa_pkg
// Types and constants shared by the file apportionment block.
// ----------------------------------------------------------------------------
package lrfa_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int IDX_BITS    = 4;
  localparam int CNT_BITS    = 5;
  localparam int FILE_BITS   = 20;
  localparam int WEIGHT_BITS = 16;
  localparam int TOT_BITS    = 24;
  localparam int WTOT_BITS   = 20;
  localparam int CACHE_BITS  = 32;
  localparam int BW_BITS     = 40;
  localparam int PROD_BITS   = 64;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_WORKER_COUNT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIG_DISABLE  = 1'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  typedef struct packed {
    logic [FILE_BITS-1:0]   current_files;
    logic [WEIGHT_BITS-1:0] worker_weight;
    logic [CACHE_BITS-1:0]  app_cache_total;
    logic [BW_BITS-1:0]     app_bandwidth_total;
    logic                   is_final;
  } in_item_t;

  typedef struct packed {
    logic                   record_kind;
    logic [IDX_BITS-1:0]    worker_index;
    logic [IDX_BITS-1:0]    dest_worker;
    logic [FILE_BITS-1:0]   file_count;
    logic [CACHE_BITS-1:0]  cache_share;
    logic [BW_BITS-1:0]     bandwidth_share;
    logic [WEIGHT_BITS-1:0] weight_out;
    logic                   error_flag;
    logic                   last_record;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PICK,
    ST_SCAN,
    ST_ALLOC,
    ST_EMIT,
    ST_MIG,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_SPLIT,
    PH_CACHE,
    PH_BW
  } phase_e;

endpackage

/* rtl/core/lrfa_div.sv */
// ----------------------------------------------------------------------------
// lrfa_div
// Restoring divider, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module lrfa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lrfa_pkg::PROD_BITS-1:0] dividend_i,
  input  logic [lrfa_pkg::TOT_BITS-1:0]  divisor_i,
  output logic                          done_o,
  output logic [lrfa_pkg::PROD_BITS-1:0] quot_o,
  output logic [lrfa_pkg::TOT_BITS-1:0]  rem_o
);
  import lrfa_pkg::*;

  localparam int STEP_BITS = $clog2(PROD_BITS);

  logic                  busy_q, done_q;
  logic [STEP_BITS-1:0]  cnt_q;
  logic [PROD_BITS-1:0]  quo_q;
  logic [TOT_BITS-1:0]   rem_q, dvs_q;
  logic [TOT_BITS:0]     trial;
  logic                  fits;
  logic [TOT_BITS:0]     diff;

  assign trial = {rem_q, quo_q[PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_BITS'(PROD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_BITS-2:0], fits};
      rem_q <= fits ? diff[TOT_BITS-1:0] : trial[TOT_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/largest_remainder_file_apportion_top.sv */
// ----------------------------------------------------------------------------
// largest_remainder_file_apportion_top
// Splits an application's files over its workers by weight, largest remainder.
// ----------------------------------------------------------------------------
// Input channel: one item per worker, in worker order, taken one per cycle
// while in_stall_o is low. The item with is_final set carries the cache and
// bandwidth totals and starts the computation; in_stall_o then stays high
// until the last record has moved into the output register.
// Output channel: n allocation records, then the migration moves (unless
// migration is disabled); last_record marks the final one. The output
// register holds its item while out_stall_i is high, and the sequencer waits.
// All work runs through one multiplier and one 64-step restoring divider.
// Each worker needs a weight split, and later its cache and bandwidth shares
// and its record; each leftover file costs a scan over the workers, and the
// move walk steps through the destination workers for each source.
// Configuration: worker_count and migration_disable must be written only while
// idle; the block itself does not enforce this.
// Reset clears counters and totals; the per-worker stores need no reset.
// ----------------------------------------------------------------------------
module largest_remainder_file_apportion_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lrfa_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lrfa_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [lrfa_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lrfa_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import lrfa_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [CNT_BITS-1:0]    wcount_q;
  logic                   mdis_q;
  logic [CNT_BITS-1:0]    load_cnt_q;
  logic [TOT_BITS-1:0]    ftot_q;
  logic [WTOT_BITS-1:0]   wtot_q;
  logic [CACHE_BITS-1:0]  cache_q;
  logic [BW_BITS-1:0]     bw_q;

  logic [FILE_BITS-1:0]   cur_mem [MAX_WORKERS];
  logic [WEIGHT_BITS-1:0] wgt_mem [MAX_WORKERS];
  logic [TOT_BITS-1:0]    nxt_mem [MAX_WORKERS];
  logic [WTOT_BITS-1:0]   rem_mem [MAX_WORKERS];
  logic [FILE_BITS-1:0]   sur_q   [MAX_WORKERS];
  logic [TOT_BITS-1:0]    need_q  [MAX_WORKERS];

  logic [MAX_WORKERS-1:0] picked_q;
  logic [CNT_BITS-1:0]    idx_q, j_q;
  logic [IDX_BITS-1:0]    best_q;
  logic                   best_v_q;
  logic [WTOT_BITS-1:0]   best_rem_q;
  logic [CNT_BITS-1:0]    left_q;
  logic [TOT_BITS-1:0]    sum_q;
  logic                   err_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [CACHE_BITS-1:0]  cs_q;
  logic [BW_BITS-1:0]     bs_q;
  out_item_t              pend_q, out_q;
  logic                   pend_v_q, out_v_q;

  logic [CNT_BITS-1:0]    n_w;
  logic                   out_free;
  logic                   ld_en, ld_store;
  logic [TOT_BITS-1:0]    ftot_n;
  logic [WTOT_BITS-1:0]   wtot_n;
  logic                   err_now;
  logic [FILE_BITS-1:0]   cur_rd;
  logic [WEIGHT_BITS-1:0] wgt_rd;
  logic [TOT_BITS-1:0]    nx;
  logic [BW_BITS-1:0]     mul_a;
  logic [TOT_BITS-1:0]    mul_b;
  logic [TOT_BITS-1:0]    dvs;
  logic                   div_go, div_done;
  logic [PROD_BITS-1:0]   div_q;
  logic [TOT_BITS-1:0]    div_r;
  logic                   split_wr, cs_wr, bs_wr, mul_en;
  logic                   scan_step, scan_commit, take;
  logic [IDX_BITS-1:0]    win;
  logic                   alloc_push, mig_push, mig_next_i, mig_next_j, fin;
  logic                   pick_start, mig_start;
  logic [FILE_BITS-1:0]   sur_rd, mv;
  logic [TOT_BITS-1:0]    need_rd;
  out_item_t              rec;
  out_item_t              last_rec;
  logic [TOT_BITS-1:0]    sum_n;

  assign n_w = (wcount_q == '0) ? CNT_BITS'(1) :
               (wcount_q > CNT_BITS'(MAX_WORKERS)) ? CNT_BITS'(MAX_WORKERS) : wcount_q;
  assign out_free = !out_v_q || !out_stall_i;

  assign ld_en    = (state_q == ST_IDLE) && in_valid_i;
  assign ld_store = ld_en && (load_cnt_q < n_w);
  assign ftot_n   = ftot_q + (ld_store ? TOT_BITS'(in_item_i.current_files) : '0);
  assign wtot_n   = wtot_q + (ld_store ? WTOT_BITS'(in_item_i.worker_weight) : '0);
  assign err_now  = (ftot_n == '0) || (wtot_n == '0);

  assign cur_rd = (idx_q < load_cnt_q) ? cur_mem[idx_q[IDX_BITS-1:0]] : '0;
  assign wgt_rd = (idx_q < load_cnt_q) ? wgt_mem[idx_q[IDX_BITS-1:0]] : '0;
  assign nx     = err_q ? '0 :
                  nxt_mem[idx_q[IDX_BITS-1:0]] + TOT_BITS'(picked_q[idx_q[IDX_BITS-1:0]]);

  always_comb begin
    unique case (phase_q)
      PH_SPLIT: begin
        mul_a = BW_BITS'(ftot_q);
        mul_b = TOT_BITS'(wgt_rd);
        dvs   = TOT_BITS'(wtot_q);
      end
      PH_CACHE: begin
        mul_a = BW_BITS'(cache_q);
        mul_b = nx;
        dvs   = ftot_q;
      end
      default: begin
        mul_a = bw_q;
        mul_b = nx;
        dvs   = ftot_q;
      end
    endcase
  end

  lrfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (prod_q),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  assign take = !picked_q[j_q[IDX_BITS-1:0]] &&
                (!best_v_q || (rem_mem[j_q[IDX_BITS-1:0]] > best_rem_q));
  assign win  = take ? j_q[IDX_BITS-1:0] : best_q;

  assign sur_rd  = sur_q[idx_q[IDX_BITS-1:0]];
  assign need_rd = need_q[j_q[IDX_BITS-1:0]];
  assign mv      = (TOT_BITS'(sur_rd) < need_rd) ? sur_rd : need_rd[FILE_BITS-1:0];
  assign sum_n   = sum_q + div_q[TOT_BITS-1:0];

  always_comb begin
    rec = '0;
    rec.error_flag   = err_q;
    rec.worker_index = idx_q[IDX_BITS-1:0];
    if (state_q == ST_MIG) begin
      rec.record_kind = KIND_MOVE;
      rec.dest_worker = j_q[IDX_BITS-1:0];
      rec.file_count  = mv;
    end else begin
      rec.record_kind     = KIND_ALLOC;
      rec.file_count      = (nx > TOT_BITS'({FILE_BITS{1'b1}})) ? {FILE_BITS{1'b1}} :
                            nx[FILE_BITS-1:0];
      rec.cache_share     = err_q ? '0 : cs_q;
      rec.bandwidth_share = err_q ? '0 : bs_q;
      rec.weight_out      = wgt_rd;
    end
  end

  always_comb begin
    last_rec             = pend_q;
    last_rec.last_record = 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    mul_en      = 1'b0;
    div_go      = 1'b0;
    split_wr    = 1'b0;
    cs_wr       = 1'b0;
    bs_wr       = 1'b0;
    scan_step   = 1'b0;
    scan_commit = 1'b0;
    alloc_push  = 1'b0;
    mig_push    = 1'b0;
    mig_next_i  = 1'b0;
    mig_next_j  = 1'b0;
    fin         = 1'b0;
    pick_start  = 1'b0;
    mig_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_item_i.is_final) begin
          if (err_now) begin
            state_d = ST_ALLOC;
          end else begin
            phase_d = PH_SPLIT;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        mul_en  = 1'b1;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (phase_q)
            PH_SPLIT: begin
              split_wr = 1'b1;
              if ((idx_q + 1'b1) == n_w) begin
                pick_start = 1'b1;
                state_d    = ST_PICK;
              end else begin
                state_d = ST_MUL;
              end
            end
            PH_CACHE: begin
              cs_wr   = 1'b1;
              phase_d = PH_BW;
              state_d = ST_MUL;
            end
            default: begin
              bs_wr   = 1'b1;
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_PICK: begin
        if (left_q == '0) begin
          state_d = ST_ALLOC;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        if ((j_q + 1'b1) == n_w) begin
          scan_commit = 1'b1;
          state_d     = ST_PICK;
        end
      end
      ST_ALLOC: begin
        if (err_q) begin
          state_d = ST_EMIT;
        end else begin
          phase_d = PH_CACHE;
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          alloc_push = 1'b1;
          if ((idx_q + 1'b1) == n_w) begin
            if (mdis_q) begin
              state_d = ST_FIN;
            end else begin
              mig_start = 1'b1;
              state_d   = ST_MIG;
            end
          end else begin
            state_d = ST_ALLOC;
          end
        end
      end
      ST_MIG: begin
        if (idx_q == n_w) begin
          state_d = ST_FIN;
        end else if ((sur_rd == '0) || (j_q == n_w)) begin
          mig_next_i = 1'b1;
        end else if (need_rd == '0) begin
          mig_next_j = 1'b1;
        end else if (out_free) begin
          mig_push   = 1'b1;
          mig_next_j = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SPLIT;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q   <= CNT_BITS'(MAX_WORKERS);
      mdis_q     <= 1'b0;
      load_cnt_q <= '0;
      ftot_q     <= '0;
      wtot_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      idx_q      <= '0;
      j_q        <= '0;
      picked_q   <= '0;
      best_v_q   <= 1'b0;
      left_q     <= '0;
      sum_q      <= '0;
      err_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WORKER_COUNT: wcount_q <= cfg_wdata_i;
          REG_MIG_DISABLE:  mdis_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (ld_en) begin
        ftot_q <= ftot_n;
        wtot_q <= wtot_n;
        if (ld_store) begin
          load_cnt_q <= load_cnt_q + 1'b1;
        end
        if (in_item_i.is_final) begin
          err_q    <= err_now;
          idx_q    <= '0;
          sum_q    <= '0;
          picked_q <= '0;
        end
      end
      if (split_wr) begin
        sum_q <= sum_n;
        if (pick_start) begin
          left_q   <= CNT_BITS'(ftot_q - sum_n);
          idx_q    <= '0;
          j_q      <= '0;
          best_v_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (scan_step) begin
        if (scan_commit) begin
          j_q      <= '0;
          best_v_q <= 1'b0;
          left_q   <= left_q - 1'b1;
          if (take || best_v_q) begin
            picked_q[win] <= 1'b1;
          end
        end else begin
          j_q <= j_q + 1'b1;
          if (take) begin
            best_v_q <= 1'b1;
          end
        end
      end
      if (alloc_push) begin
        idx_q <= mig_start ? '0 : idx_q + 1'b1;
        j_q   <= '0;
      end
      if (mig_next_i) begin
        idx_q <= idx_q + 1'b1;
        j_q   <= '0;
      end
      if (mig_next_j) begin
        j_q <= j_q + 1'b1;
      end
      if (fin || ((alloc_push || mig_push) && pend_v_q)) begin
        out_v_q <= 1'b1;
      end else begin
        out_v_q <= out_v_q && out_stall_i;
      end
      if (alloc_push || mig_push) begin
        pend_v_q <= 1'b1;
      end
      if (fin) begin
        pend_v_q   <= 1'b0;
        load_cnt_q <= '0;
        ftot_q     <= '0;
        wtot_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_store) begin
      cur_mem[load_cnt_q[IDX_BITS-1:0]] <= in_item_i.current_files;
      wgt_mem[load_cnt_q[IDX_BITS-1:0]] <= in_item_i.worker_weight;
    end
    if (ld_en && in_item_i.is_final) begin
      cache_q <= in_item_i.app_cache_total;
      bw_q    <= in_item_i.app_bandwidth_total;
    end
    if (mul_en) begin
      prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end
    if (split_wr) begin
      nxt_mem[idx_q[IDX_BITS-1:0]] <= div_q[TOT_BITS-1:0];
      rem_mem[idx_q[IDX_BITS-1:0]] <= div_r[WTOT_BITS-1:0];
    end
    if (scan_step && take && !scan_commit) begin
      best_q     <= j_q[IDX_BITS-1:0];
      best_rem_q <= rem_mem[j_q[IDX_BITS-1:0]];
    end
    if (scan_step && !scan_commit && !take && !best_v_q) begin
      best_q <= best_q;
    end
    if (cs_wr) begin
      cs_q <= div_q[CACHE_BITS-1:0] + CACHE_BITS'(div_r != '0);
    end
    if (bs_wr) begin
      bs_q <= div_q[BW_BITS-1:0] + BW_BITS'(div_r != '0);
    end
    if (alloc_push) begin
      sur_q[idx_q[IDX_BITS-1:0]]  <= (TOT_BITS'(cur_rd) > nx) ?
                                     cur_rd - nx[FILE_BITS-1:0] : '0;
      need_q[idx_q[IDX_BITS-1:0]] <= (nx > TOT_BITS'(cur_rd)) ? nx - TOT_BITS'(cur_rd) : '0;
    end
    if (mig_push) begin
      sur_q[idx_q[IDX_BITS-1:0]] <= sur_rd - mv;
      need_q[j_q[IDX_BITS-1:0]]  <= need_rd - TOT_BITS'(mv);
    end
    if (alloc_push || mig_push) begin
      pend_q <= rec;
      if (pend_v_q) begin
        out_q <= pend_q;
      end
    end
    if (fin) begin
      out_q <= last_rec;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/lrfa_checker.sv */
// ----------------------------------------------------------------------------
// lrfa_port_checker
// Port-level checks on the file apportionment block, bound to the top level.
// ----------------------------------------------------------------------------
`include "largest_remainder_file_apportion_top_assert.svh"

module lrfa_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input lrfa_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lrfa_pkg::out_item_t out_item_o
);
  import lrfa_pkg::*;

  `LRFA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `LRFA_ASSERT_NXT(a_busy_after_final, in_valid_i && !in_stall_o && in_item_i.is_final, in_stall_o)
  `LRFA_ASSERT_IMP(a_err_zero, out_valid_o && out_item_o.error_flag, out_item_o.cache_share == '0 && out_item_o.bandwidth_share == '0)
  `LRFA_ASSERT_IMP(a_move_fields, out_valid_o && (out_item_o.record_kind == KIND_MOVE), out_item_o.weight_out == '0 && out_item_o.file_count != '0)

endmodule

bind largest_remainder_file_apportion_top lrfa_port_checker u_lrfa_checker (.*);

/* dv/lrfa_checker.sv */
// ----------------------------------------------------------------------------
// lrfa_checker
// Watches the item, result and register ports of the file apportionment block.
// Keeps its own model of the per-worker stores. On each final item it works out
// the allocation and move records by exact integer arithmetic. It compares
// every record the block hands over, field by field, with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module lrfa_checker
  import lrfa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  in_item_t                 in_item_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  out_item_t                out_item_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       records_o
);

  logic [FILE_BITS-1:0]   files_mem [MAX_WORKERS];
  logic [WEIGHT_BITS-1:0] weight_mem[MAX_WORKERS];
  int                     loaded;
  logic [63:0]            file_sum;
  logic [63:0]            weight_sum;
  logic [4:0]             workers_cfg;
  logic                   no_moves;
  out_item_t              owed_q[$];
  int                     fails;
  int                     seen;

  assign fail_count_o = fails;
  assign pending_o    = owed_q.size();
  assign records_o    = seen;

  function automatic logic [FILE_BITS-1:0] clip_files(logic [63:0] v);
    return (v > 64'(2**FILE_BITS - 1)) ? FILE_BITS'(2**FILE_BITS - 1) : v[FILE_BITS-1:0];
  endfunction

  function automatic logic [63:0] ceil_part(logic [63:0] total, logic [63:0] part,
                                            logic [63:0] whole);
    logic [127:0] prod;
    prod = 128'(total) * 128'(part);
    return 64'((prod + 128'(whole) - 1) / 128'(whole));
  endfunction

  task automatic apportion(in_item_t it);
    int          n;
    int          best;
    logic [63:0] cur [MAX_WORKERS];
    logic [63:0] wt  [MAX_WORKERS];
    logic [63:0] nxt [MAX_WORKERS];
    logic [63:0] rem [MAX_WORKERS];
    logic [63:0] over[MAX_WORKERS];
    logic [63:0] need[MAX_WORKERS];
    logic        took[MAX_WORKERS];
    logic [63:0] tot_f, tot_w, sum, left, mv;
    logic        err;
    out_item_t   rec;
    out_item_t   recs[$];
    n = (workers_cfg == 0) ? 1 : ((workers_cfg > MAX_WORKERS) ? MAX_WORKERS : workers_cfg);
    if (loaded < n) begin
      files_mem[loaded]  = it.current_files;
      weight_mem[loaded] = it.worker_weight;
      file_sum   += it.current_files;
      weight_sum += it.worker_weight;
      loaded++;
    end
    if (!it.is_final) return;
    tot_f = file_sum;
    tot_w = weight_sum;
    err = (tot_f == 0) || (tot_w == 0);
    sum = 0;
    for (int i = 0; i < n; i++) begin
      cur[i] = (i < loaded) ? 64'(files_mem[i]) : 0;
      wt[i]  = (i < loaded) ? 64'(weight_mem[i]) : 0;
      nxt[i] = err ? 0 : (tot_f * wt[i]) / tot_w;
      rem[i] = err ? 0 : (tot_f * wt[i]) % tot_w;
      sum += nxt[i];
      took[i] = 1'b0;
    end
    left = err ? 0 : tot_f - sum;
    while (left > 0) begin
      best = -1;
      for (int i = 0; i < n; i++)
        if (!took[i] && (best < 0 || rem[i] > rem[best])) best = i;
      if (best < 0) break;
      took[best] = 1'b1;
      nxt[best]++;
      left--;
    end
    for (int i = 0; i < n; i++) begin
      rec = '0;
      rec.record_kind     = KIND_ALLOC;
      rec.worker_index    = IDX_BITS'(i);
      rec.file_count      = clip_files(nxt[i]);
      rec.cache_share     = err ? '0 : CACHE_BITS'(ceil_part(it.app_cache_total, nxt[i], tot_f));
      rec.bandwidth_share = err ? '0 : BW_BITS'(ceil_part(it.app_bandwidth_total, nxt[i], tot_f));
      rec.weight_out      = WEIGHT_BITS'(wt[i]);
      rec.error_flag      = err;
      recs.push_back(rec);
      over[i] = (cur[i] > nxt[i]) ? cur[i] - nxt[i] : 0;
      need[i] = (nxt[i] > cur[i]) ? nxt[i] - cur[i] : 0;
    end
    if (!no_moves) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n && over[i] > 0; j++) begin
          if (need[j] == 0) continue;
          mv = (over[i] < need[j]) ? over[i] : need[j];
          over[i] -= mv;
          need[j] -= mv;
          rec = '0;
          rec.record_kind  = KIND_MOVE;
          rec.worker_index = IDX_BITS'(i);
          rec.dest_worker  = IDX_BITS'(j);
          rec.file_count   = clip_files(mv);
          rec.error_flag   = err;
          recs.push_back(rec);
        end
    end
    recs[recs.size()-1].last_record = 1'b1;
    foreach (recs[k]) owed_q.push_back(recs[k]);
    loaded = 0;
    file_sum = 0;
    weight_sum = 0;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      fails++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      loaded      = 0;
      file_sum    = 0;
      weight_sum  = 0;
      workers_cfg = 5'd16;
      no_moves    = 1'b0;
      fails       = 0;
      seen        = 0;
      owed_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WORKER_COUNT) workers_cfg = cfg_wdata_i;
        else if (cfg_index_i == REG_MIG_DISABLE) no_moves = cfg_wdata_i[0];
      end
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t unexpected record: expected none, actual %0h", $time, out_item_i);
        end else begin
          exp_r = owed_q.pop_front();
          check_field("record_kind", exp_r.record_kind, out_item_i.record_kind);
          check_field("worker_index", exp_r.worker_index, out_item_i.worker_index);
          check_field("dest_worker", exp_r.dest_worker, out_item_i.dest_worker);
          check_field("file_count", exp_r.file_count, out_item_i.file_count);
          check_field("cache_share", exp_r.cache_share, out_item_i.cache_share);
          check_field("bandwidth_share", exp_r.bandwidth_share, out_item_i.bandwidth_share);
          check_field("weight_out", exp_r.weight_out, out_item_i.weight_out);
          check_field("error_flag", exp_r.error_flag, out_item_i.error_flag);
          check_field("last_record", exp_r.last_record, out_item_i.last_record);
        end
      end
      if (in_valid_i && !in_stall_i) apportion(in_item_i);
    end
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives worker items and register writes into the file apportionment block.
// A directed set covers ties, extremes, zero totals, early and surplus items
// and the move switch. Random applications then follow under several worker
// counts, with random idling on both sides. The checker does the predicting.
// ----------------------------------------------------------------------------
module tb;
  import lrfa_pkg::*;

  localparam int IDLE_LIMIT = 30000;
  localparam int RANDOM_ITEMS = 210;

  logic                     clk;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_item;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int                       fail_count;
  int                       pending;
  int                       records;
  int                       items_sent;
  int                       apps_sent;
  int                       idle_cycles;
  logic                     quiet;
  logic                     hold_req;
  logic                     hold_done;
  logic [4:0]               cur_workers;

  largest_remainder_file_apportion_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  lrfa_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .records_o   (records)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_done <= 1'b1;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [4:0] workers, logic no_moves);
    write_reg(REG_WORKER_COUNT, workers);
    write_reg(REG_MIG_DISABLE, CFG_DATA_BITS'(no_moves));
    cur_workers = workers;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send(in_item_t it);
    logic stalled;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
    if (it.is_final) apps_sent++;
  endtask

  function automatic in_item_t pick_item(logic last);
    in_item_t it;
    case ($urandom_range(0, 5))
      0: it.current_files = '0;
      1: it.current_files = '1;
      2: it.current_files = FILE_BITS'($urandom_range(0, 15));
      5: it.current_files = FILE_BITS'($urandom);
      default: it.current_files = FILE_BITS'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 5))
      0: it.worker_weight = '0;
      1: it.worker_weight = '1;
      2: it.worker_weight = WEIGHT_BITS'($urandom_range(0, 7));
      5: it.worker_weight = WEIGHT_BITS'($urandom);
      default: it.worker_weight = WEIGHT_BITS'($urandom_range(0, 500));
    endcase
    case ($urandom_range(0, 7))
      0: it.app_cache_total = '0;
      1: it.app_cache_total = '1;
      default: it.app_cache_total = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: it.app_bandwidth_total = '0;
      1: it.app_bandwidth_total = '1;
      default: it.app_bandwidth_total = {8'($urandom), 32'($urandom)};
    endcase
    it.is_final = last;
    return it;
  endfunction

  function automatic in_item_t make_item(int files, int weight, logic last);
    in_item_t it;
    it = '0;
    it.current_files       = FILE_BITS'(files);
    it.worker_weight       = WEIGHT_BITS'(weight);
    it.app_cache_total     = 32'd1000;
    it.app_bandwidth_total = 40'd77777;
    it.is_final            = last;
    return it;
  endfunction

  task automatic send_app(int count);
    for (int i = 0; i < count; i++) send(pick_item(i == count - 1));
  endtask

  initial begin
    in_item_t   it;
    int         eff;
    int         count;
    int         sel;
    logic [4:0] modes[10] = '{5'd2, 5'd5, 5'd1, 5'd16, 5'd31, 5'd3, 5'd0, 5'd7, 5'd4, 5'd2};
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_WORKER_COUNT;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    apps_sent   = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    set_mode(5'd3, 1'b0);
    send(make_item(10, 1, 1'b0));
    send(make_item(0, 1, 1'b0));
    send(make_item(0, 1, 1'b1));
    it = '1;
    send(it);
    it.worker_weight = 16'd1;
    send(it);
    it.is_final = 1'b1;
    it.worker_weight = '1;
    send(it);
    send(make_item(0, 5, 1'b0));
    send(make_item(0, 9, 1'b0));
    send(make_item(0, 0, 1'b1));
    send(make_item(4, 0, 1'b0));
    send(make_item(7, 0, 1'b0));
    send(make_item(1, 0, 1'b1));
    send(make_item(9, 3, 1'b1));
    for (int i = 0; i < 5; i++) send(make_item(3 + i, 2 * i + 1, i == 4));
    in_valid <= 1'b0;
    wait_drained();
    set_mode(5'd3, 1'b1);
    send(make_item(100, 1, 1'b0));
    send(make_item(0, 2, 1'b0));
    send(make_item(0, 4, 1'b1));
    in_valid <= 1'b0;
    wait_drained();
    set_mode(5'd0, 1'b0);
    send(make_item(12345, 77, 1'b1));
    in_valid <= 1'b0;
    wait_drained();

    sel = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_mode(modes[sel % 10], 1'($urandom_range(0, 1)));
      eff = (cur_workers == 0) ? 1 : ((cur_workers > MAX_WORKERS) ? MAX_WORKERS : cur_workers);
      if (sel == 1) hold_req = 1'b1;
      if (items_sent > RANDOM_ITEMS - 40) quiet = 1'b1;
      repeat ((eff > 8) ? 2 : 4) begin
        case ($urandom_range(0, 9))
          0: count = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
          1: count = eff + $urandom_range(1, 3);
          default: count = eff;
        endcase
        send_app(count);
      end
      in_valid <= 1'b0;
      wait_drained();
      sel++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d items in %0d applications, %0d records checked,", items_sent,
             apps_sent, records);
    $display("over worker counts 0 to 31 with moves on and off.");
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
